// ===== hw/rtl/multinomial_particle_resampler_assert.svh =====
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Clocked assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef MULTINOMIAL_PARTICLE_RESAMPLER_ASSERT_SVH
`define MULTINOMIAL_PARTICLE_RESAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked only out of reset.
`define MPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPR_ASSERT(lbl, prop, msg)
`define MPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/mpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Resampler package
// Field widths, codes, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mpr_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int WEIGHT_BITS_DEF   = 16;

  localparam int CFG_W       = 11;
  localparam int WEIGHT_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int IDX_OUT_W   = 10;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_W-1:0] COUNT_RESET = 11'd100;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERRUN = 2'd2;

  typedef struct packed {
    logic load;      // apply a load word
    logic capture;   // latch the draw fraction
    logic mul;       // form target, set search bounds
    logic search;    // one binary-search step
    logic out_load;  // move result to the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic zero;      // total weight is zero
    logic done;      // search bounds have met
  } ctl_sts_t;

endpackage

// ===== hw/rtl/mpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpr_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mpr_datapath.sv =====
// ----------------------------------------------------------------------------
// Resampler datapath
// Cumulative weight store, target multiply and binary-search bounds.
// ----------------------------------------------------------------------------
module mpr_datapath #(
  parameter int MAX_PARTICLES = mpr_pkg::MAX_PARTICLES_DEF,
  parameter int WEIGHT_BITS   = mpr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpr_pkg::ctl_cmd_t            cmd,
  output mpr_pkg::ctl_sts_t            sts,
  input  logic                         cfg_we,
  input  logic [mpr_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_first,
  input  logic [mpr_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [mpr_pkg::FRAC_W-1:0]   in_fraction,
  output logic [mpr_pkg::IDX_OUT_W-1:0] out_index,
  output logic [mpr_pkg::ST_W-1:0]     out_status
);
  import mpr_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = IDX_W + 1;
  localparam int SUM_W = WEIGHT_BITS + IDX_W;
  localparam int TGT_W = SUM_W + FRAC_W;
  localparam int PCW   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WXW   = (WEIGHT_BITS > WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int OXW   = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

  logic [CFG_W-1:0]     pc_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     total_r, total_nxt;
  logic [FRAC_W-1:0]    frac_r;
  logic [TGT_W-1:0]     target_r;
  logic [CNT_W-1:0]     lo_r, hi_r, limit_r;
  logic [IDX_W-1:0]     mid_r;
  logic [IDX_W-1:0]     res_idx_r;
  logic [ST_W-1:0]      res_st_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [ST_W-1:0]      out_st_r;

  logic [PCW-1:0]       pc_ext, eff_wide;
  logic [CNT_W-1:0]     eff;
  logic [CNT_W-1:0]     base_cnt;
  logic [SUM_W-1:0]     base_tot;
  logic [WXW-1:0]       w_ext;
  logic [SUM_W-1:0]     wr_sum;
  logic                 wr_en;
  logic [CNT_W-1:0]     lim;
  logic [SUM_W-1:0]     ram_rdata;
  logic                 hit;
  logic [CNT_W-1:0]     lo_nxt, hi_nxt;
  logic [CNT_W-1:0]     bnd_a, bnd_b;
  logic [CNT_W:0]       bnd_sum;
  logic [IDX_W-1:0]     raddr;
  logic [CNT_W-1:0]     limit_m1;
  logic [OXW-1:0]       res_ext;

  // Clamp the register to [1, MAX_PARTICLES].
  always_comb begin
    pc_ext = PCW'(pc_r);
    if (pc_ext == '0) begin
      eff_wide = PCW'(1);
    end else if (pc_ext > PCW'(MAX_PARTICLES)) begin
      eff_wide = PCW'(MAX_PARTICLES);
    end else begin
      eff_wide = pc_ext;
    end
  end
  assign eff = eff_wide[CNT_W-1:0];

  // Load path: clear on the first word of a set, append while room is left.
  assign base_cnt  = in_first ? '0 : cnt_r;
  assign base_tot  = in_first ? '0 : total_r;
  assign w_ext     = WXW'(in_weight);
  assign wr_sum    = base_tot + SUM_W'(w_ext[WEIGHT_BITS-1:0]);
  assign wr_en     = cmd.load && (base_cnt < eff);
  assign cnt_nxt   = wr_en ? base_cnt + CNT_W'(1) : base_cnt;
  assign total_nxt = wr_en ? wr_sum : base_tot;

  assign lim       = (cnt_r > eff) ? eff : cnt_r;
  assign sts.zero  = (total_r == '0) || (cnt_r == '0);

  // Search step on the word read at mid_r.
  assign hit    = {ram_rdata, {FRAC_W{1'b0}}} >= target_r;
  assign lo_nxt = hit ? lo_r : CNT_W'(mid_r) + CNT_W'(1);
  assign hi_nxt = hit ? CNT_W'(mid_r) : hi_r;
  assign sts.done = (lo_nxt >= hi_nxt);

  assign bnd_a   = cmd.mul ? '0  : lo_nxt;
  assign bnd_b   = cmd.mul ? lim : hi_nxt;
  assign bnd_sum = {1'b0, bnd_a} + {1'b0, bnd_b};
  assign raddr   = bnd_sum[IDX_W:1];

  assign limit_m1 = limit_r - CNT_W'(1);

  mpr_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_PARTICLES)
  ) u_sums (
    .clk  (clk),
    .we   (wr_en),
    .waddr(base_cnt[IDX_W-1:0]),
    .wdata(wr_sum),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= COUNT_RESET;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
      if (cmd.load) begin
        cnt_r   <= cnt_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frac_r <= in_fraction;
    end
    if (cmd.mul) begin
      target_r <= TGT_W'(frac_r) * TGT_W'(total_r);
      lo_r     <= '0;
      hi_r     <= lim;
      limit_r  <= lim;
      if (sts.zero) begin
        res_idx_r <= '0;
        res_st_r  <= ST_ZERO;
      end
    end
    if (cmd.search) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      if (sts.done) begin
        if (lo_nxt == limit_r) begin
          res_idx_r <= limit_m1[IDX_W-1:0];
          res_st_r  <= ST_OVERRUN;
        end else begin
          res_idx_r <= lo_nxt[IDX_W-1:0];
          res_st_r  <= ST_OK;
        end
      end
    end
    if (cmd.mul || cmd.search) begin
      mid_r <= raddr;
    end
    if (cmd.out_load) begin
      out_idx_r <= res_ext[IDX_OUT_W-1:0];
      out_st_r  <= res_st_r;
    end
  end

  assign res_ext    = OXW'(res_idx_r);
  assign out_index  = out_idx_r;
  assign out_status = out_st_r;

endmodule

// ===== hw/rtl/mpr_controller.sv =====
// ----------------------------------------------------------------------------
// Resampler controller
// Sequences loads, draw search steps and the output register.
// ----------------------------------------------------------------------------
module mpr_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_is_draw,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  output mpr_pkg::ctl_cmd_t cmd,
  input  mpr_pkg::ctl_sts_t sts
);
  import mpr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MUL    = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_is_draw == CMD_DRAW) begin
            cmd.capture = 1'b1;
            state_nxt   = S_MUL;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.zero ? S_DONE : S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/multinomial_particle_resampler.sv =====
// Timing: a load word is written in the cycle it is accepted; a draw word is captured,
// passes the multiply state, k = ceil(log2(n+1)) search steps over n loaded entries
// (k = 11 at 1024) and the done state, then its result is offered; a zero total skips the search.
// Throughput: one load per cycle while no draw is in flight; a draw holds off input
// words until its result moves to the output register; one RAM read per search step.
// Reset: synchronous, active low; clears count, total, handshake; particle_count to 100.
// ----------------------------------------------------------------------------
// Multinomial particle resampler
// Builds a cumulative weight table from load words and answers each draw
// word with the first particle whose cumulative weight reaches r * total.
// ----------------------------------------------------------------------------
`include "multinomial_particle_resampler_assert.svh"

module multinomial_particle_resampler #(
  parameter int MAX_PARTICLES = mpr_pkg::MAX_PARTICLES_DEF,
  parameter int WEIGHT_BITS   = mpr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: particle_count
  input  logic                            cfg_we,
  input  logic [mpr_pkg::CFG_W-1:0]       cfg_wdata,
  // Input words
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mpr_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] weight, [31:16] random_fraction
  input  logic [mpr_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] command, [1] first_weight
  // Result words
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mpr_pkg::OUT_TDATA_W-1:0] out_tdata   // [9:0] chosen_index, [11:10] status
);
  import mpr_pkg::*;

  ctl_cmd_t             cmd;
  ctl_sts_t             sts;
  logic [IDX_OUT_W-1:0] res_index;
  logic [ST_W-1:0]      res_status;

  // Sequencer: accepts words only between draws, holds a finished result
  // until the output register frees up.
  mpr_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_is_draw(in_tuser[0]),
    .in_tready (in_tready),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: cumulative-sum RAM, target multiply, binary-search bounds.
  mpr_datapath #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_first   (in_tuser[1]),
    .in_weight  (in_tdata[WEIGHT_W-1:0]),
    .in_fraction(in_tdata[WEIGHT_W +: FRAC_W]),
    .out_index  (res_index),
    .out_status (res_status)
  );

  // Pad the result word to whole bytes.
  assign out_tdata = {{(OUT_TDATA_W - IDX_OUT_W - ST_W){1'b0}}, res_status, res_index};

  // A draw holds off further input words.
  `MPR_ASSERT(a_draw_busy, (in_tvalid && in_tready && in_tuser[0]) |=> !in_tready, "no stall")
  // Never overwrite a result that is still waiting.
  `MPR_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_tvalid || out_tready), "result overwritten")
  // A zero-total answer always names particle 0.
  `MPR_ASSERT(a_zero_index, (out_tvalid && res_status == ST_ZERO) |-> res_index == '0, "zero idx")
  // Reset drops any pending result.
  `MPR_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Multinomial particle resampler testbench
// Streams load and draw words into the resampler and holds a cycle-free
// predictor of the cumulative weight table. Every draw result is checked
// against it in order. Runs a directed opening, then random weight sets over
// many particle_count settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpr_pkg::*;

  localparam int SLOTS          = MAX_PARTICLES_DEF;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
  localparam int REPORT_LIMIT   = 10;

  // One input word as the stimulus sees it.
  typedef struct packed {
    logic                cmd;
    logic                starts_set;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   frac;
  } word_t;

  // One draw result.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [ST_W-1:0]      status;
  } draw_result_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;   // [15:0] weight, [31:16] random_fraction
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;   // [0] command, [1] first_weight
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [9:0] chosen_index, [11:10] status

  // Stimulus queue and the draw results still owed by the block.
  word_t        pending_words[$];
  draw_result_t expected_draws[$];
  word_t        cur_word;

  int words_queued   = 0;
  int words_accepted = 0;
  int draws_checked  = 0;
  int mismatches     = 0;
  int count_writes   = 0;
  int idle_cycles    = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  bit quiet          = 1'b0;  // no idling on either side once set

  // Predictor state: register copy and cumulative weight table.
  logic [CFG_W-1:0] count_reg;
  logic [25:0]      cum_weight[SLOTS];
  logic [25:0]      set_total;
  int               set_size;

  always #6 clk = ~clk;

  multinomial_particle_resampler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Register value as the block uses it: zero acts as one, cap at the table size.
  function automatic int active_count();
    int n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // A set start clears the table even when the set is full.
  function automatic void append_weight(logic starts, logic [WEIGHT_W-1:0] weight);
    if (starts) begin
      set_size  = 0;
      set_total = '0;
    end
    if (set_size >= active_count()) return;
    set_total            = set_total + 26'(weight);
    cum_weight[set_size] = set_total;
    set_size++;
  endfunction

  // First particle with cum * 2^16 >= r * total; walk only the active part.
  function automatic draw_result_t pick_particle(logic [FRAC_W-1:0] frac);
    draw_result_t res;
    logic [41:0]  target;
    int           limit;
    res.index  = '0;
    res.status = ST_ZERO;
    if (set_total == 0 || set_size == 0) return res;
    limit  = (set_size < active_count()) ? set_size : active_count();
    target = 42'(frac) * 42'(set_total);
    for (int i = 0; i < limit; i++) begin
      if ({cum_weight[i], 16'h0000} >= target) begin
        res.index  = IDX_OUT_W'(i);
        res.status = ST_OK;
        return res;
      end
    end
    // Only reachable after particle_count was lowered below the loaded size.
    res.index  = IDX_OUT_W'(limit - 1);
    res.status = ST_OVERRUN;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feed words from the queue, apply each accepted word to the predictor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  = 0;
      count_reg = COUNT_RESET;
      set_size  = 0;
      set_total = '0;
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        if (cur_word.cmd == CMD_LOAD) append_weight(cur_word.starts_set, cur_word.weight);
        else expected_draws.push_back(pick_particle(cur_word.frac));
        // Count after the expectation is queued so a drain check never sees a gap.
        words_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          cur_word   = pending_words.pop_front();
          in_tdata   <= {cur_word.frac, cur_word.weight};
          in_tuser   <= {cur_word.starts_set, cur_word.cmd};
          next_valid = 1'b1;
          // Idle for a burst once this word has gone.
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : collect
    draw_result_t want;
    draw_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.index  = out_tdata[IDX_OUT_W-1:0];
        got.status = out_tdata[IDX_OUT_W +: ST_W];
        draws_checked++;
        if (expected_draws.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result word: index %0d status %0d", got.index, got.status);
          mismatches++;
        end else begin
          want = expected_draws.pop_front();
          if (got.index !== want.index || got.status !== want.status) begin
            if (mismatches < REPORT_LIMIT)
              $display("draw %0d mismatch: expected index %0d status %0d, got index %0d status %0d",
                       draws_checked, want.index, want.status, got.index, got.status);
            mismatches++;
          end
        end
      end
      // Stall bursts: out_tready drops now and stays low while recv_gap counts down.
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        recv_gap   = $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles in which no word moves
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_draws.size());
    $display("** multinomial_particle_resampler: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_word(logic cmd, logic starts, logic [WEIGHT_W-1:0] weight,
                           logic [FRAC_W-1:0] frac);
    word_t w;
    w.cmd        = cmd;
    w.starts_set = starts;
    w.weight     = weight;
    w.frac       = frac;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Weight styles: full range, tiny (ties and zeros), all zero, rails only.
  function automatic logic [WEIGHT_W-1:0] rand_weight(int style);
    case (style)
      0: return WEIGHT_W'($urandom_range(0, 65535));
      1: return WEIGHT_W'($urandom_range(0, 3));
      2: return '0;
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return FRAC_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_draw(logic [FRAC_W-1:0] frac);
    push_word(CMD_DRAW, 1'($urandom_range(0, 1)), WEIGHT_W'($urandom), frac);
  endtask

  // One weight set with a few draws mixed in and after it.
  task automatic queue_set(int n_loads, int n_draws, int style);
    for (int k = 0; k < n_loads; k++) begin
      push_word(CMD_LOAD, k == 0, rand_weight(style), FRAC_W'($urandom));
      if ($urandom_range(0, 7) == 0) push_draw(rand_frac());
    end
    for (int k = 0; k < n_draws; k++) push_draw(rand_frac());
  endtask

  // Wait for every word to be taken and every result to arrive, then let
  // the block finish any load still in flight.
  task automatic settle();
    while (words_accepted != words_queued || expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_writes++;
  endtask

  // Mostly well-formed sets, some of them overfilled, plus random noise words.
  task automatic random_phase(logic [CFG_W-1:0] value, int budget);
    int start;
    int cap;
    start = words_queued;
    cap   = (value == 0) ? 1 : (value > 20 ? 20 : int'(value));
    write_count(value);
    while (words_queued - start < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          push_word(1'($urandom), 1'($urandom), WEIGHT_W'($urandom), FRAC_W'($urandom));
      end else begin
        queue_set($urandom_range(1, cap + 2), $urandom_range(1, 6), $urandom_range(0, 3));
      end
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, zero total, rails of every field, draw flag ignored.
    push_word(CMD_DRAW, 1'b1, '0, '0);
    push_word(CMD_LOAD, 1'b1, '0, '0);
    push_word(CMD_LOAD, 1'b0, '0, '0);
    push_word(CMD_DRAW, 1'b0, '0, '1);
    push_word(CMD_LOAD, 1'b1, '1, '0);
    push_word(CMD_LOAD, 1'b0, '0, '0);
    push_word(CMD_LOAD, 1'b0, '1, '0);
    push_word(CMD_LOAD, 1'b0, 16'd1, '0);
    push_word(CMD_DRAW, 1'b0, '0, '0);
    push_word(CMD_DRAW, 1'b0, '0, '1);
    push_word(CMD_DRAW, 1'b0, '0, 16'h8000);
    push_word(CMD_DRAW, 1'b1, '1, 16'h0001);
    settle();

    // Full set: extra loads drop, a set start on a full set still restarts it.
    write_count(11'd3);
    push_word(CMD_LOAD, 1'b1, 16'd5, '0);
    push_word(CMD_LOAD, 1'b0, 16'd7, '0);
    push_word(CMD_LOAD, 1'b0, 16'd9, '0);
    push_word(CMD_LOAD, 1'b0, 16'd11, '0);
    push_word(CMD_DRAW, 1'b0, '0, '1);
    push_word(CMD_LOAD, 1'b1, 16'h1234, '0);
    push_word(CMD_LOAD, 1'b0, '1, '0);
    push_word(CMD_LOAD, 1'b0, '1, '0);
    push_word(CMD_DRAW, 1'b0, '0, 16'h0001);
    settle();

    // Shrink the count below the loaded size: walk overruns and clamps.
    write_count(11'd1);
    push_word(CMD_DRAW, 1'b0, '0, '1);
    push_word(CMD_DRAW, 1'b0, '0, '0);
    settle();
    write_count(11'd2047);
    push_word(CMD_DRAW, 1'b0, '0, 16'h7FFF);
    settle();

    // Random sets across many counts, extremes included.
    random_phase(11'd1, 25);
    random_phase(11'd2, 25);
    random_phase(11'd5, 30);
    random_phase(11'd0, 20);
    random_phase(11'd16, 35);
    random_phase(CFG_W'($urandom_range(1, 64)), 35);
    random_phase(11'd1024, 30);

    // Load a deep set, then lower the count for a run of overrun draws.
    write_count(11'd40);
    queue_set(40, 4, 0);
    settle();
    write_count(CFG_W'($urandom_range(2, 6)));
    repeat (12) push_draw(rand_frac());
    settle();
    write_count(11'd0);
    repeat (6) push_draw(rand_frac());
    settle();

    // One large set so the upper index bits show up.
    write_count(11'd2047);
    queue_set(530, 0, 0);
    repeat (16)
      push_draw(($urandom_range(0, 1) != 0) ? FRAC_W'($urandom_range(16'hF800, 16'hFFFF))
                                            : rand_frac());
    settle();

    // Last stretch at full rate, no idling on either side.
    quiet = 1'b1;
    random_phase(11'd100, 35);

    $display("%0d words sent over %0d particle_count writes, %0d draw results checked",
             words_accepted, count_writes, draws_checked);
    $display("%0d mismatches, %0d results left unmatched", mismatches, expected_draws.size());
    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("** multinomial_particle_resampler: PASSED **");
    end else begin
      $display("** multinomial_particle_resampler: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mpr_pkg.sv
hw/rtl/mpr_ram.sv
hw/rtl/mpr_datapath.sv
hw/rtl/mpr_controller.sv
hw/rtl/multinomial_particle_resampler.sv
test/tb.sv
